// ----- rtl/core/bprs_pkg.sv -----
// Shared constants, register codes and types for the byte pattern replace stream unit.
`timescale 1ns / 1ps

package bprs_pkg;

    // Default sizes of the pattern window and the replacement buffer, in bytes
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_W  = 4;

    // Depth of the descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Reset value of the pattern length register
    localparam logic [CFG_LEN_W-1:0] PLEN_RESET = CFG_LEN_W'(1);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_LENGTH     = 2'd0,
        REG_PATTERN_BYTES      = 2'd1,
        REG_REPLACEMENT_LENGTH = 2'd2,
        REG_REPLACEMENT_BYTES  = 2'd3
    } cfg_reg_t;

    // End-of-string flags that travel with each descriptor
    typedef struct packed {
        logic last;
        logic replaced;
    } desc_ctrl_t;

endpackage

// ----- rtl/core/byte_pattern_replace_stream_unit.sv -----
// Top level of the streaming byte pattern find-and-replace unit.
// Throughput: one input item per cycle while in_ready is high; an item yields 0 to 8 result
// items, one per cycle while out_ready is high. Rate is set by the back end, which expands one
// descriptor byte per cycle while out_ready is high; a four-entry descriptor queue absorbs
// replacement bursts before the input side stalls. Reset clears configuration to defaults,
// the window and queue counts and all valid flags; window bytes hold none.
`timescale 1ns / 1ps

module byte_pattern_replace_stream_unit #(
    parameter int MAX_PATTERN     = bprs_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = bprs_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bprs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bprs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            byte_present,
    output logic                            out_last,
    output logic                            any_replaced
);
    import bprs_pkg::*;

    localparam int DESC_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int COUNT_W    = $clog2(DESC_BYTES + 1);
    localparam int CTRL_W     = $bits(desc_ctrl_t);
    localparam int Q_WIDTH    = CTRL_W + COUNT_W + DESC_BYTES*8;

    logic                    push_valid;
    logic                    push_ready;
    logic [DESC_BYTES*8-1:0] push_bytes;
    logic [COUNT_W-1:0]      push_count;
    desc_ctrl_t              push_ctrl;
    logic                    pop_valid;
    logic                    pop_ready;
    logic [Q_WIDTH-1:0]      pop_data;

    // Front end: window and classification
    bprs_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .DESC_BYTES      (DESC_BYTES),
        .COUNT_W         (COUNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_bytes (push_bytes),
        .push_count (push_count),
        .push_ctrl  (push_ctrl)
    );

    // Descriptor queue
    bprs_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctrl, push_count, push_bytes}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: result expansion and output register
    bprs_back #(
        .DESC_BYTES (DESC_BYTES),
        .COUNT_W    (COUNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_bytes    (pop_data[DESC_BYTES*8-1:0]),
        .pop_count    (pop_data[DESC_BYTES*8 +: COUNT_W]),
        .pop_ctrl     (desc_ctrl_t'(pop_data[Q_WIDTH-1 -: CTRL_W])),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .out_last     (out_last),
        .any_replaced (any_replaced)
    );

endmodule

// ----- rtl/core/bprs_front.sv -----
// Front end: configuration registers, match window and per-item classification.
`timescale 1ns / 1ps

module bprs_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int DESC_BYTES      = 8,
    parameter int COUNT_W         = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bprs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bprs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [DESC_BYTES*8-1:0]         push_bytes,
    output logic [COUNT_W-1:0]              push_count,
    output bprs_pkg::desc_ctrl_t            push_ctrl
);
    import bprs_pkg::*;

    localparam int WC_W = $clog2(MAX_PATTERN + 1);
    localparam int RL_W = $clog2(MAX_REPLACEMENT + 1);

    // Configuration registers
    logic [CFG_LEN_W-1:0]           plen_cfg_reg, plen_cfg_next;
    logic [MAX_PATTERN*8-1:0]       pattern_reg, pattern_next;
    logic [CFG_LEN_W-1:0]           rlen_cfg_reg, rlen_cfg_next;
    logic [MAX_REPLACEMENT*8-1:0]   repl_reg, repl_next;

    // Window state
    logic [7:0]      window_reg [MAX_PATTERN];
    logic [7:0]      window_next [MAX_PATTERN];
    logic [WC_W-1:0] wcount_reg, wcount_next;
    logic            replaced_reg, replaced_next;

    // Classification signals
    logic                     accept;
    logic [WC_W-1:0]          plen_eff;
    logic [RL_W-1:0]          rlen_eff;
    logic [WC_W-1:0]          wc_use;
    logic [WC_W-1:0]          wc_new;
    logic [7:0]               nw [MAX_PATTERN];
    logic [MAX_PATTERN*8-1:0] nw_flat;
    logic                     compare;
    logic                     match_all;
    logic                     hit;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    // Effective lengths, with out-of-range settings clamped
    always_comb
    begin
        if (plen_cfg_reg == '0)
            plen_eff = WC_W'(1);
        else if (plen_cfg_reg > CFG_LEN_W'(MAX_PATTERN))
            plen_eff = WC_W'(MAX_PATTERN);
        else
            plen_eff = WC_W'(plen_cfg_reg);

        if (rlen_cfg_reg > CFG_LEN_W'(MAX_REPLACEMENT))
            rlen_eff = RL_W'(MAX_REPLACEMENT);
        else
            rlen_eff = RL_W'(rlen_cfg_reg);
    end

    // Append the new byte to the window and compare against the pattern
    always_comb
    begin
        wc_use    = (wcount_reg >= plen_eff) ? '0 : wcount_reg;
        wc_new    = wc_use + WC_W'(1);
        compare   = (wc_new == plen_eff);
        match_all = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            nw[k] = (WC_W'(k) == wc_use) ? in_byte : window_reg[k];
            nw_flat[8*k +: 8] = nw[k];
            if ((WC_W'(k) < plen_eff) && (nw[k] != pattern_reg[8*k +: 8]))
                match_all = 1'b0;
        end
        hit = compare && match_all;
    end

    // Descriptor handed to the back end
    always_comb
    begin
        if (hit)
        begin
            push_bytes = (DESC_BYTES*8)'(repl_reg);
            push_count = COUNT_W'(rlen_eff);
        end
        else
        begin
            push_bytes = (DESC_BYTES*8)'(nw_flat);
            if (in_last)
                push_count = COUNT_W'(wc_new);
            else if (compare)
                push_count = COUNT_W'(1);
            else
                push_count = '0;
        end
        push_ctrl.last     = in_last;
        push_ctrl.replaced = in_last && (replaced_reg || hit);
        push_valid         = accept && (in_last || (push_count != '0));
    end

    // Next state of configuration and window
    always_comb
    begin
        plen_cfg_next = plen_cfg_reg;
        pattern_next  = pattern_reg;
        rlen_cfg_next = rlen_cfg_reg;
        repl_next     = repl_reg;
        wcount_next   = wcount_reg;
        replaced_next = replaced_reg;
        window_next   = window_reg;

        if (accept)
        begin
            if (compare && !hit)
            begin
                for (int k = 0; k < MAX_PATTERN - 1; k++)
                    window_next[k] = nw[k+1];
                window_next[MAX_PATTERN-1] = nw[MAX_PATTERN-1];
            end
            else
            begin
                window_next = nw;
            end

            if (in_last || hit)
                wcount_next = '0;
            else if (compare)
                wcount_next = wc_new - WC_W'(1);
            else
                wcount_next = wc_new;

            replaced_next = in_last ? 1'b0 : (replaced_reg || hit);
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_LENGTH:
                begin
                    plen_cfg_next = cfg_data[CFG_LEN_W-1:0];
                    wcount_next   = '0;
                end
                REG_PATTERN_BYTES:      pattern_next  = cfg_data[MAX_PATTERN*8-1:0];
                REG_REPLACEMENT_LENGTH: rlen_cfg_next = cfg_data[CFG_LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  repl_next     = cfg_data[MAX_REPLACEMENT*8-1:0];
                default:                ;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_cfg_reg <= PLEN_RESET;
            pattern_reg  <= '0;
            rlen_cfg_reg <= '0;
            repl_reg     <= '0;
            wcount_reg   <= '0;
            replaced_reg <= 1'b0;
        end
        else
        begin
            plen_cfg_reg <= plen_cfg_next;
            pattern_reg  <= pattern_next;
            rlen_cfg_reg <= rlen_cfg_next;
            repl_reg     <= repl_next;
            wcount_reg   <= wcount_next;
            replaced_reg <= replaced_next;
        end
    end

    // Window bytes carry no reset; only entries below the count are ever read
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    // The pending byte count always stays below the pattern length
    assert property (@(posedge clk) disable iff (!rst_n) wcount_reg < plen_eff)
        else $error("window count reached the pattern length");

endmodule

// ----- rtl/core/bprs_queue.sv -----
// Small descriptor queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module bprs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage entries hold payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // The front end never offers a descriptor while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n) push_valid |-> push_ready)
        else $error("descriptor offered to a full queue");

endmodule

// ----- rtl/core/bprs_back.sv -----
// Back end: expands descriptors into result items through a registered output stage.
`timescale 1ns / 1ps

module bprs_back #(
    parameter int DESC_BYTES = 8,
    parameter int COUNT_W    = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  logic [DESC_BYTES*8-1:0] pop_bytes,
    input  logic [COUNT_W-1:0]      pop_count,
    input  bprs_pkg::desc_ctrl_t    pop_ctrl,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    byte_present,
    output logic                    out_last,
    output logic                    any_replaced
);
    import bprs_pkg::*;

    // Descriptor being expanded
    logic                    cur_valid_reg, cur_valid_next;
    logic [DESC_BYTES*8-1:0] cur_bytes_reg, cur_bytes_next;
    logic [COUNT_W-1:0]      cur_rem_reg, cur_rem_next;
    desc_ctrl_t              cur_ctrl_reg, cur_ctrl_next;

    // Output stage
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       present_reg, present_next;
    logic       last_reg, last_next;
    logic       any_reg, any_next;

    logic advance;
    logic emit;
    logic cur_done;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && advance;
    assign cur_done  = (cur_rem_reg <= COUNT_W'(1));
    assign pop_ready = !cur_valid_reg || (emit && cur_done);

    // Emit one result per cycle unless stalled and load the next descriptor behind the last one
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_bytes_next = cur_bytes_reg;
        cur_rem_next   = cur_rem_reg;
        cur_ctrl_next  = cur_ctrl_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        present_next   = present_reg;
        last_next      = last_reg;
        any_next       = any_reg;

        if (advance)
            out_valid_next = emit;

        if (emit)
        begin
            present_next   = (cur_rem_reg != '0);
            out_byte_next  = (cur_rem_reg != '0) ? cur_bytes_reg[7:0] : 8'h00;
            last_next      = cur_ctrl_reg.last && cur_done;
            any_next       = cur_ctrl_reg.replaced && cur_ctrl_reg.last && cur_done;
            cur_bytes_next = cur_bytes_reg >> 8;
            cur_rem_next   = (cur_rem_reg != '0) ? cur_rem_reg - COUNT_W'(1) : '0;
            if (cur_done)
                cur_valid_next = 1'b0;
        end

        if (pop_valid && pop_ready)
        begin
            cur_valid_next = 1'b1;
            cur_bytes_next = pop_bytes;
            cur_rem_next   = pop_count;
            cur_ctrl_next  = pop_ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_bytes_reg <= cur_bytes_next;
        cur_rem_reg   <= cur_rem_next;
        cur_ctrl_reg  <= cur_ctrl_next;
        out_byte_reg  <= out_byte_next;
        present_reg   <= present_next;
        last_reg      <= last_next;
        any_reg       <= any_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_present = present_reg;
    assign out_last     = last_reg;
    assign any_replaced = any_reg;

    // An empty marker is only ever the final item of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !present_reg) |-> last_reg)
        else $error("empty marker without end flag");

    // A descriptor with no bytes exists only to carry the end of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && (cur_rem_reg == '0)) |-> cur_ctrl_reg.last)
        else $error("empty descriptor without end flag");

endmodule
